@@ hdl/rlf_pkg.sv @@
package rlf_pkg;

  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int SUM1_BITS  = COORD_BITS + COUNT_BITS;
  localparam int SUM2_BITS  = 2 * COORD_BITS - 1 + COUNT_BITS;
  localparam int ACC_BITS   = 2 * SUM2_BITS - 12;
  localparam int MUL_STEPS  = SUM2_BITS + 1;
  localparam int NUM_BITS   = ACC_BITS + FRAC_BITS;
  localparam int STEP_BITS  = $clog2(NUM_BITS);

  localparam logic [COUNT_BITS-1:0] MAX_POINTS = COUNT_BITS'(4095);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_VERTICAL = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  // saturate a quotient magnitude with its sign to signed 32 bits
  function automatic logic [31:0] sat32(input logic neg, input logic ovf,
                                        input logic [31:0] q);
    logic [31:0] r;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) r = 32'h8000_0000;
      else r = 32'd0 - q;
    end else begin
      if (ovf || q > 32'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = q;
    end
    return r;
  endfunction

endpackage

@@ hdl/running_line_fit.sv @@
// Running least-squares line fit. Each input beat adds (tuser 0) or removes (tuser 1) one
// point and yields one output beat with slope and offset in signed Q16.16, the point count
// and a status. Internally a bit-serial multiply-accumulate builds the determinant and both
// numerators from the running sums (six products), and a restoring divider produces each
// quotient one bit a cycle. Fits with fewer than two points, rejected removes and vertical
// fits finish without running the divider. The input is not ready while an item is in work.
module running_line_fit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_coord, y_coord
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // slope_q, offset_q, point_count, status
);
  import rlf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD_XY, S_UPD_XX, S_FIT, S_MAC, S_DIV, S_OUT
  } state_e;

  state_e                        state_q;
  logic [COUNT_BITS-1:0]         count_q;
  logic signed [SUM1_BITS-1:0]   sx_q, sy_q;
  logic signed [SUM2_BITS-1:0]   sxy_q, sxx_q;
  logic                          cmd_q;
  logic signed [COORD_BITS-1:0]  x_q, y_q;
  status_e                       status_q;
  logic [31:0]                   slope_res_q, offset_res_q;
  logic signed [ACC_BITS-1:0]    acc_q, mcand_q;
  logic signed [MUL_STEPS-1:0]   mplier_q;
  logic [STEP_BITS-1:0]          step_q;
  logic [2:0]                    idx_q;
  logic [ACC_BITS-1:0]           den_q, rem_q;
  logic                          den_neg_q, qneg_q, ovf_q;
  logic [NUM_BITS-1:0]           num_q;
  logic [31:0]                   quo_q;
  logic                          out_valid_q;
  logic [79:0]                   out_data_q;

  logic signed [2*COORD_BITS-1:0] prod_w;
  logic signed [SUM2_BITS-1:0]    prod_ext;
  logic signed [ACC_BITS-1:0]     acc_d, mc_load;
  logic signed [MUL_STEPS-1:0]    mp_load;
  logic [2:0]                     ld_idx;
  logic [ACC_BITS-1:0]            acc_mag;
  logic [ACC_BITS:0]              rem_sh, rem_sub;
  logic                           qbit;
  logic [31:0]                    quo_d, div_res;
  logic                           ovf_d;
  logic [31:0]                    lone_off;
  logic signed [MUL_STEPS-1:0]    n_ext;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // one small multiplier shared by both sum updates
  assign prod_w   = (state_q == S_UPD_XY) ? x_q * y_q : x_q * x_q;
  assign prod_ext = SUM2_BITS'(prod_w);

  assign n_ext = MUL_STEPS'({1'b0, count_q});

  // operand selection for the multiply-accumulate: odd products are subtracted
  always_comb begin
    ld_idx = (state_q == S_FIT) ? 3'd0 : idx_q + 3'd1;
    case (ld_idx)
      3'd0: begin mc_load = ACC_BITS'(sxx_q); mp_load = n_ext; end
      3'd1: begin mc_load = ACC_BITS'(sx_q);  mp_load = MUL_STEPS'(sx_q); end
      3'd2: begin mc_load = ACC_BITS'(sxy_q); mp_load = n_ext; end
      3'd3: begin mc_load = ACC_BITS'(sx_q);  mp_load = MUL_STEPS'(sy_q); end
      3'd4: begin mc_load = ACC_BITS'(sxx_q); mp_load = MUL_STEPS'(sy_q); end
      3'd5: begin mc_load = ACC_BITS'(sxy_q); mp_load = MUL_STEPS'(sx_q); end
      default: begin mc_load = '0; mp_load = '0; end
    endcase
  end

  // shift-add step, the top multiplier bit carries negative weight
  always_comb begin
    acc_d = acc_q;
    if (mplier_q[0]) begin
      if ((step_q == STEP_BITS'(MUL_STEPS - 1)) ^ idx_q[0]) acc_d = acc_q - mcand_q;
      else acc_d = acc_q + mcand_q;
    end
    acc_mag = acc_d[ACC_BITS-1] ? ACC_BITS'(-acc_d) : ACC_BITS'(acc_d);
  end

  // restoring divider step
  always_comb begin
    rem_sh  = {rem_q, num_q[NUM_BITS-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    qbit    = (rem_sh >= {1'b0, den_q});
    quo_d   = {quo_q[30:0], qbit};
    ovf_d   = ovf_q | quo_q[31];
    div_res = sat32(qneg_q, ovf_d, quo_d);
  end

  // offset of a lone point: y shifted to Q16.16, saturated
  always_comb begin
    if (sy_q > SUM1_BITS'(32767)) lone_off = 32'h7FFF_FFFF;
    else if (sy_q < -SUM1_BITS'(32768)) lone_off = 32'h8000_0000;
    else lone_off = {sy_q[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxy_q       <= '0;
      sxx_q       <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      step_q      <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q        <= s_axis_tuser;
            x_q          <= s_axis_tdata[15:0];
            y_q          <= s_axis_tdata[31:16];
            slope_res_q  <= '0;
            offset_res_q <= '0;
            if (s_axis_tuser == CMD_ADD && count_q == MAX_POINTS) begin
              status_q <= ST_FULL;
              state_q  <= S_FIT;
            end else if (s_axis_tuser == CMD_REMOVE && count_q == '0) begin
              status_q <= ST_EMPTY;
              state_q  <= S_OUT;
            end else begin
              status_q <= ST_OK;
              state_q  <= S_UPD_XY;
            end
          end
        end
        S_UPD_XY: begin
          if (cmd_q == CMD_ADD) begin
            count_q <= count_q + 1'b1;
            sx_q    <= sx_q + SUM1_BITS'(x_q);
            sy_q    <= sy_q + SUM1_BITS'(y_q);
            sxy_q   <= sxy_q + prod_ext;
          end else begin
            count_q <= count_q - 1'b1;
            sx_q    <= sx_q - SUM1_BITS'(x_q);
            sy_q    <= sy_q - SUM1_BITS'(y_q);
            sxy_q   <= sxy_q - prod_ext;
          end
          state_q <= S_UPD_XX;
        end
        S_UPD_XX: begin
          if (cmd_q == CMD_ADD) sxx_q <= sxx_q + prod_ext;
          else sxx_q <= sxx_q - prod_ext;
          state_q <= S_FIT;
        end
        S_FIT: begin
          if (count_q < COUNT_BITS'(2)) begin
            if (count_q == COUNT_BITS'(1)) offset_res_q <= lone_off;
            state_q <= S_OUT;
          end else begin
            acc_q    <= '0;
            idx_q    <= '0;
            step_q   <= '0;
            mcand_q  <= mc_load;
            mplier_q <= mp_load;
            state_q  <= S_MAC;
          end
        end
        S_MAC: begin
          if (step_q == STEP_BITS'(MUL_STEPS - 1)) begin
            step_q <= '0;
            if (!idx_q[0]) begin
              acc_q    <= acc_d;
              idx_q    <= ld_idx;
              mcand_q  <= mc_load;
              mplier_q <= mp_load;
            end else if (idx_q == 3'd1) begin
              if (acc_d == '0) begin
                if (status_q != ST_FULL) status_q <= ST_VERTICAL;
                state_q <= S_OUT;
              end else begin
                den_q     <= acc_mag;
                den_neg_q <= acc_d[ACC_BITS-1];
                acc_q     <= '0;
                idx_q     <= ld_idx;
                mcand_q   <= mc_load;
                mplier_q  <= mp_load;
              end
            end else begin
              num_q   <= {acc_mag, {FRAC_BITS{1'b0}}};
              qneg_q  <= acc_d[ACC_BITS-1] ^ den_neg_q;
              rem_q   <= '0;
              quo_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_DIV;
            end
          end else begin
            acc_q    <= acc_d;
            mcand_q  <= mcand_q <<< 1;
            mplier_q <= mplier_q >>> 1;
            step_q   <= step_q + 1'b1;
          end
        end
        S_DIV: begin
          num_q  <= num_q << 1;
          rem_q  <= qbit ? rem_sub[ACC_BITS-1:0] : rem_sh[ACC_BITS-1:0];
          quo_q  <= quo_d;
          ovf_q  <= ovf_d;
          if (step_q == STEP_BITS'(NUM_BITS - 1)) begin
            step_q <= '0;
            if (idx_q == 3'd3) begin
              slope_res_q <= div_res;
              acc_q       <= '0;
              idx_q       <= ld_idx;
              mcand_q     <= mc_load;
              mplier_q    <= mp_load;
              state_q     <= S_MAC;
            end else begin
              offset_res_q <= div_res;
              state_q      <= S_OUT;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {2'b00, status_q, count_q, offset_res_q, slope_res_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
